@@ rtl/core/clipped_rgb_pixel_row_writer_macros.svh @@
// Assertion macros for the clipped RGB pixel row writer.
// Expects clk and rst_n in the scope of use; define NO_ASSERTIONS to drop them.
`ifndef CLIPPED_RGB_PIXEL_ROW_WRITER_MACROS_SVH
`define CLIPPED_RGB_PIXEL_ROW_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CRPW_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define CRPW_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define CRPW_ASSERT_IMP(name, pre, post, msg)
`define CRPW_ASSERT_NXT(name, pre, post, msg)

`endif

`endif

@@ rtl/core/crpw_pkg.sv @@
// Shared types and constants for the clipped RGB pixel row writer.
// No dependencies.
`timescale 1ns / 1ps

package crpw_pkg;

  localparam int MASK_WIDTH = 8;
  localparam int LANE_W     = (MASK_WIDTH > 1) ? $clog2(MASK_WIDTH) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ROW_W = 29;   // 13-bit row times 16-bit pitch
  localparam int T_W   = 24;   // scaled channel numerator
  localparam int Q_W   = 16;   // scaled channel result

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED,
    REG_PITCH,
    REG_WIDTH,
    REG_HEIGHT,
    REG_BPP,
    REG_RED_FMT,
    REG_GREEN_FMT,
    REG_BLUE_FMT
  } cfg_reg_t;

  typedef struct packed {
    logic        enabled;
    logic [15:0] pitch_bytes;
    logic [12:0] clip_width;
    logic [12:0] clip_height;
    logic [5:0]  bits_per_pixel;
    logic [8:0]  red_format;
    logic [8:0]  green_format;
    logic [8:0]  blue_format;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [23:0]        rgb_color;
    logic [7:0]         pixel_mask;
  } in_word_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic [31:0] pixel_value;
    logic [2:0]  byte_count;
    logic        is_last;
  } out_word_t;

  // one classified item waiting for the back end
  typedef struct packed {
    logic [ROW_W-1:0]      row_base;
    logic [15:0]           x0;
    logic [MASK_WIDTH-1:0] lanes;       // bit i: pixel at x0+i is written
    logic [31:0]           pixel_value;
    logic [2:0]            byte_count;
    logic [2:0]            stride;
  } work_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

@@ rtl/core/crpw_front.sv @@
// Front end: takes words, clips each pixel, scales and packs the colour.
// Three register stages; depends on crpw_pkg.
`timescale 1ns / 1ps

module crpw_front import crpw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  input  q_status_t q_status,
  output logic      push,
  output work_t     push_data
);

  localparam int BUSY_W = QCNT_W + 1;

  logic     accept;
  logic     s1_v_r;
  in_word_t s1_item_r;

  logic                  s2_v_r;
  work_t                 s2_work_r;
  logic [T_W-1:0]        s2_t_r   [3];
  logic [4:0]            s2_pos_r [3];

  logic                  s3_v_r;
  work_t                 s3_work_r;
  logic [T_W-1:0]        s3_t_r   [3];
  logic [Q_W-1:0]        s3_q0_r  [3];
  logic [4:0]            s3_pos_r [3];

  // stage 1 logic
  logic [7:0]            chan   [3];
  logic [3:0]            size_c [3];
  logic [4:0]            pos_c  [3];
  logic [T_W-1:0]        t_c    [3];
  logic signed [16:0]    x_lane [MASK_WIDTH];
  logic [MASK_WIDTH-1:0] lanes;
  logic [2:0]            bpp_bytes;
  logic [2:0]            wr_count;
  logic                  y_ok;
  logic                  use_default;
  logic [ROW_W-1:0]      row_base;
  logic                  s1_keep;

  // stage 2 and 3 logic
  logic [31:0]           prod   [3];
  logic [Q_W-1:0]        q0_c   [3];
  logic [T_W-1:0]        back_c [3];
  logic [T_W-1:0]        rem_c  [3];
  logic [Q_W-1:0]        q_c    [3];
  logic [31:0]           packed_val;

  logic [BUSY_W-1:0]     inflight;

  // everything in the pipe will land in the queue at worst
  assign inflight = BUSY_W'(q_status.count) + BUSY_W'(s1_v_r) + BUSY_W'(s2_v_r)
                  + BUSY_W'(s3_v_r);
  assign busy     = inflight >= BUSY_W'(QUEUE_DEPTH);
  assign accept   = start && !busy;

  always_comb begin
    chan[0] = s1_item_r.rgb_color[23:16];
    chan[1] = s1_item_r.rgb_color[15:8];
    chan[2] = s1_item_r.rgb_color[7:0];
    size_c[0] = cfg.red_format[3:0];
    size_c[1] = cfg.green_format[3:0];
    size_c[2] = cfg.blue_format[3:0];
    pos_c[0]  = cfg.red_format[8:4];
    pos_c[1]  = cfg.green_format[8:4];
    pos_c[2]  = cfg.blue_format[8:4];

    use_default = (size_c[0] == 4'd0) && (size_c[1] == 4'd0) && (size_c[2] == 4'd0)
               && (cfg.bits_per_pixel >= 6'd24);
    if (use_default) begin
      size_c[0] = 4'd8; pos_c[0] = 5'd16;
      size_c[1] = 4'd8; pos_c[1] = 5'd8;
      size_c[2] = 4'd8; pos_c[2] = 5'd0;
    end

    // v*(2^n-1)+127, the divide by 255 follows in stages 2 and 3
    for (int c = 0; c < 3; c++) begin
      t_c[c] = (T_W'(chan[c]) << size_c[c]) - T_W'(chan[c]) + T_W'(127);
    end

    for (int i = 0; i < MASK_WIDTH; i++) begin
      x_lane[i] = 17'(s1_item_r.pos_x) + 17'(i);
      lanes[i]  = s1_item_r.pixel_mask[MASK_WIDTH-1-i] && !x_lane[i][16]
               && (x_lane[i][15:0] < {3'b000, cfg.clip_width});
    end

    bpp_bytes = cfg.bits_per_pixel[5:3];
    wr_count  = (bpp_bytes > 3'd4) ? 3'd4 : bpp_bytes;
    y_ok      = !s1_item_r.pos_y[15]
             && (16'(s1_item_r.pos_y) < {3'b000, cfg.clip_height});
    row_base  = ROW_W'(s1_item_r.pos_y[12:0]) * ROW_W'(cfg.pitch_bytes);
    s1_keep   = s1_v_r && cfg.enabled && (bpp_bytes != 3'd0) && y_ok && (|lanes);
  end

  // t/255 within one below: floor(t*257/65536)
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = (32'(s2_t_r[c]) << 8) + 32'(s2_t_r[c]);
      q0_c[c] = prod[c][31:16];
    end
  end

  always_comb begin
    packed_val = '0;
    for (int c = 0; c < 3; c++) begin
      back_c[c]  = (T_W'(s3_q0_r[c]) << 8) - T_W'(s3_q0_r[c]);
      rem_c[c]   = s3_t_r[c] - back_c[c];
      q_c[c]     = s3_q0_r[c] + ((rem_c[c] >= T_W'(255)) ? Q_W'(1) : Q_W'(0));
      packed_val = packed_val | (32'(q_c[c]) << s3_pos_r[c]);
    end
    push_data             = s3_work_r;
    push_data.pixel_value = packed_val;
  end

  assign push = s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_keep;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    s2_work_r.row_base    <= row_base;
    s2_work_r.x0          <= s1_item_r.pos_x;
    s2_work_r.lanes       <= lanes;
    s2_work_r.pixel_value <= '0;
    s2_work_r.byte_count  <= wr_count;
    s2_work_r.stride      <= bpp_bytes;
    s3_work_r             <= s2_work_r;
    for (int c = 0; c < 3; c++) begin
      s2_t_r[c]   <= t_c[c];
      s2_pos_r[c] <= pos_c[c];
      s3_t_r[c]   <= s2_t_r[c];
      s3_q0_r[c]  <= q0_c[c];
      s3_pos_r[c] <= s2_pos_r[c];
    end
  end

endmodule

@@ rtl/core/crpw_queue.sv @@
// Short queue of classified words between front and back end.
// Depends on crpw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "clipped_rgb_pixel_row_writer_macros.svh"

module crpw_queue import crpw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  work_t     push_data,
  input  logic      pop,
  output work_t     head,
  output q_status_t status
);

  work_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `CRPW_ASSERT_IMP(a_no_overflow, push && !pop, count_r != QCNT_W'(QUEUE_DEPTH), "queue overflow")
  `CRPW_ASSERT_IMP(a_no_underflow, pop, count_r != '0, "pop from empty queue")
  `CRPW_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count lost a word")

endmodule

@@ rtl/core/crpw_back.sv @@
// Back end: issues one pixel write a cycle, while it holds a word, from the word at the queue head.
// Depends on crpw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "clipped_rgb_pixel_row_writer_macros.svh"

module crpw_back import crpw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  work_t     head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_strobe,
  output out_word_t out_data
);

  logic                  cur_v_r, cur_v_nxt;
  work_t                 cur_r;
  logic [MASK_WIDTH-1:0] rem_r, rem_nxt;
  logic [MASK_WIDTH-1:0] sel_oh;
  logic [MASK_WIDTH-1:0] rem_after;
  logic [LANE_W-1:0]     sel_idx;
  logic [15:0]           x_pix;
  logic [15:0]           x_bytes;
  logic                  last;

  logic                  out_strobe_r;
  out_word_t             out_data_r;

  always_comb begin
    sel_oh    = rem_r & (~rem_r + MASK_WIDTH'(1));   // lowest pending pixel
    rem_after = rem_r & ~sel_oh;
    sel_idx   = '0;
    for (int i = 0; i < MASK_WIDTH; i++) begin
      if (sel_oh[i]) begin
        sel_idx = LANE_W'(i);
      end
    end
    // a pending pixel is on screen, so x fits 13 bits
    x_pix   = cur_r.x0 + 16'(sel_idx);
    x_bytes = 16'(x_pix[12:0]) * 16'(cur_r.stride);
    last    = cur_v_r && (rem_after == '0);
    pop     = !q_status.empty && (!cur_v_r || last);

    cur_v_nxt = cur_v_r;
    rem_nxt   = rem_r;
    if (pop) begin
      cur_v_nxt = 1'b1;
      rem_nxt   = head.lanes;
    end else if (last) begin
      cur_v_nxt = 1'b0;
    end else if (cur_v_r) begin
      rem_nxt = rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      cur_v_r      <= cur_v_nxt;
      out_strobe_r <= cur_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (pop) begin
      cur_r <= head;
    end
    out_data_r.byte_offset <= 32'(cur_r.row_base) + 32'(x_bytes);
    out_data_r.pixel_value <= cur_r.pixel_value;
    out_data_r.byte_count  <= cur_r.byte_count;
    out_data_r.is_last     <= last;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `CRPW_ASSERT_NXT(a_burst_unbroken, out_strobe_r && !out_data_r.is_last, out_strobe_r, "write burst broken before last pixel")
  `CRPW_ASSERT_IMP(a_pop_when_free, pop, !cur_v_r || last, "head taken while a word is in progress")
  `CRPW_ASSERT_IMP(a_count_nonzero, out_strobe_r, out_data_r.byte_count != 3'd0, "write of zero bytes")

endmodule

@@ rtl/core/clipped_rgb_pixel_row_writer.sv @@
// Top level of the clipped RGB pixel row writer: register file and wiring.
// Depends on crpw_pkg, crpw_front, crpw_queue and crpw_back.
`timescale 1ns / 1ps

// A word (position, colour, eight-pixel row mask) is taken when start is high
// and busy is low. Each selected on-screen pixel gives one write on out_data,
// strobed by out_strobe for a single cycle; the receiver cannot stall, so it
// must take a write on every strobe. With the back end idle, the first write
// of a word passes the three front stages, the queue and the back end's word
// and output registers. A word gives one to eight pixel writes, at one pixel
// write per cycle while the back end holds a word; it takes the next queued
// word as it writes the last pixel. Words that write nothing are dropped in
// the front end and never reach the queue. busy is high while four words are
// held between the three front stages and the four-entry queue.
// Registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no word is in flight.

module clipped_rgb_pixel_row_writer import crpw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_data,
  output logic                  out_strobe,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg_r;
  work_t     push_data;
  work_t     head;
  q_status_t q_status;
  logic      push;
  logic      pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled        <= 1'b0;
      cfg_r.pitch_bytes    <= '0;
      cfg_r.clip_width     <= '0;
      cfg_r.clip_height    <= '0;
      cfg_r.bits_per_pixel <= 6'd32;
      cfg_r.red_format     <= '0;
      cfg_r.green_format   <= '0;
      cfg_r.blue_format    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLED:   cfg_r.enabled        <= cfg_data[0];
        REG_PITCH:     cfg_r.pitch_bytes    <= cfg_data;
        REG_WIDTH:     cfg_r.clip_width     <= cfg_data[12:0];
        REG_HEIGHT:    cfg_r.clip_height    <= cfg_data[12:0];
        REG_BPP:       cfg_r.bits_per_pixel <= cfg_data[5:0];
        REG_RED_FMT:   cfg_r.red_format     <= cfg_data[8:0];
        REG_GREEN_FMT: cfg_r.green_format   <= cfg_data[8:0];
        REG_BLUE_FMT:  cfg_r.blue_format    <= cfg_data[8:0];
      endcase
    end
  end

  crpw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  crpw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  crpw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
